@@ sv/iplc_pkg.sv @@
// Shared types, constants and helpers for the image plane layout calculator.
// Used by every module of the block; depends on nothing.
package iplc_pkg;

    localparam int DIM_BITS   = 14;
    localparam int ALIGN_BITS = 13;
    localparam int PITCH_BITS = 16;
    localparam int SIZE_BITS  = 30;
    localparam int OFFS_BITS  = 31;
    localparam int REM_BITS   = ALIGN_BITS + 1;
    localparam int HAL_BITS   = DIM_BITS + 1;
    localparam int PROD_BITS  = PITCH_BITS + HAL_BITS;
    localparam int ACC_BITS   = OFFS_BITS + 1;

    localparam logic [2:0] FMT_YUV420 = 3'd0;
    localparam logic [2:0] FMT_NV12   = 3'd1;
    localparam logic [2:0] FMT_NV21   = 3'd2;
    localparam logic [2:0] FMT_RGB    = 3'd3;
    localparam logic [2:0] FMT_BGR    = 3'd4;
    localparam logic [2:0] FMT_RGBP   = 3'd5;
    localparam logic [2:0] FMT_BGRP   = 3'd6;

    localparam logic REG_ALIGN_W = 1'b0;
    localparam logic REG_ALIGN_H = 1'b1;

    localparam logic [PITCH_BITS-1:0] PITCH_MAX = '1;
    localparam logic [SIZE_BITS-1:0]  SIZE_MAX  = '1;
    localparam logic [OFFS_BITS-1:0]  OFFS_MAX  = '1;

    // One plane to lay out, handed from front to back
    typedef struct packed {
        logic [1:0]          plane_index;
        logic [DIM_BITS-1:0] plane_width;
        logic [DIM_BITS-1:0] plane_height;
        logic [1:0]          bpp;
        logic [1:0]          count;
        logic                err;
        logic                last;
    } cmd_t;

    typedef struct packed {
        logic [1:0]            plane_index;
        logic [DIM_BITS-1:0]   plane_width;
        logic [DIM_BITS-1:0]   plane_height;
        logic [1:0]            bpp;
        logic [PITCH_BITS-1:0] pitch;
        logic [SIZE_BITS-1:0]  plane_size;
        logic [OFFS_BITS-1:0]  plane_offset;
        logic [1:0]            count;
        logic                  err;
        logic                  last;
    } res_t;

    function automatic logic [1:0] plane_count(input logic [2:0] fmt);
        logic [1:0] c;
        case (fmt)
            FMT_YUV420, FMT_RGBP, FMT_BGRP: c = 2'd3;
            FMT_NV12, FMT_NV21:             c = 2'd2;
            FMT_RGB, FMT_BGR:               c = 2'd1;
            default:                        c = 2'd0;
        endcase
        return c;
    endfunction

    // One restoring remainder step
    function automatic logic [REM_BITS-1:0] rem_step(input logic [REM_BITS-1:0] rem,
                                                     input logic bit_in,
                                                     input logic [ALIGN_BITS-1:0] a);
        logic [REM_BITS:0] t;
        t = {rem, bit_in};
        if (t >= {2'b00, a})
            t = t - {2'b00, a};
        return t[REM_BITS-1:0];
    endfunction

endpackage

@@ sv/iplc_front.sv @@
// Front end: accepts image items and splits them into per-plane commands.
// Depends on iplc_pkg.
module iplc_front
    import iplc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          format,
    input  logic [DIM_BITS-1:0] image_width,
    input  logic [DIM_BITS-1:0] image_height,
    output logic                cmd_push,
    input  logic                cmd_full,
    output cmd_t                cmd
);

    logic                busy_reg, busy_next;
    logic [2:0]          fmt_reg;
    logic [DIM_BITS-1:0] w_reg, h_reg;
    logic [1:0]          idx_reg, idx_next;
    logic [1:0]          cnt;
    logic                accept;

    assign cnt      = plane_count(fmt_reg);
    assign cmd_push = busy_reg && !cmd_full;
    assign full     = busy_reg && !(cmd_push && cmd.last);
    assign accept   = push && !full;

    always_comb
    begin
        cmd              = '0;
        cmd.plane_index  = idx_reg;
        cmd.plane_width  = w_reg;
        cmd.plane_height = h_reg;
        cmd.bpp          = 2'd1;
        cmd.count        = cnt;
        cmd.last         = (idx_reg + 2'd1 == cnt) || (cnt == 2'd0);
        cmd.err          = (cnt == 2'd0);
        if (cnt == 2'd0)
        begin
            cmd.plane_index  = '0;
            cmd.plane_width  = '0;
            cmd.plane_height = '0;
            cmd.bpp          = '0;
        end
        else if (fmt_reg == FMT_YUV420 && idx_reg != 2'd0)
        begin
            cmd.plane_width  = w_reg >> 1;
            cmd.plane_height = h_reg >> 1;
        end
        else if ((fmt_reg == FMT_NV12 || fmt_reg == FMT_NV21) && idx_reg != 2'd0)
        begin
            cmd.plane_height = h_reg >> 1;
        end
        else if (fmt_reg == FMT_RGB || fmt_reg == FMT_BGR)
        begin
            cmd.bpp = 2'd3;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (cmd_push)
        begin
            idx_next = idx_reg + 2'd1;
            if (cmd.last)
                busy_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fmt_reg <= format;
            w_reg   <= image_width;
            h_reg   <= image_height;
        end
    end

endmodule

@@ sv/iplc_cmd_fifo.sv @@
// Four-entry command queue between front and back.
// Depends on iplc_pkg.
module iplc_cmd_fifo
    import iplc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd,
    output cmd_t rd_data,
    output logic valid
);

    cmd_t       mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] n_reg;

    assign full    = (n_reg == 3'd4);
    assign valid   = (n_reg != 3'd0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg  <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 2'd1;
            if (rd)
                rp_reg <= rp_reg + 2'd1;
            n_reg <= n_reg + {2'b00, wr} - {2'b00, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

@@ sv/iplc_back.sv @@
// Back end: bit-serial remainder unit, pitch/size multiply, offset sum and
// a two-entry result queue. Depends on iplc_pkg.
module iplc_back
    import iplc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    input  logic [ALIGN_BITS-1:0] align_w,
    input  logic [ALIGN_BITS-1:0] align_h,
    output logic                  res_valid,
    output res_t                  res,
    input  logic                  res_pop
);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_RND, S_MUL, S_OUT} state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic [PITCH_BITS-1:0] dw_reg, shw_reg;
    logic [PITCH_BITS-1:0] shh_reg;
    logic [REM_BITS-1:0]   rw_reg, rh_reg;
    logic [3:0]            step_reg;
    logic [PITCH_BITS-1:0] pitch_reg;
    logic [HAL_BITS-1:0]   hal_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [ACC_BITS-1:0]   offs_reg;

    res_t                  q_reg [2];
    logic                  qw_reg, qr_reg;
    logic [1:0]            qn_reg;
    logic                  q_wr;
    res_t                  q_in;

    logic [PITCH_BITS:0]   pw_sum;
    logic [HAL_BITS-1:0]   ph_sum;
    logic [SIZE_BITS-1:0]  size_sat;

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign res_valid = (qn_reg != 2'd0);
    assign res       = q_reg[qr_reg];
    assign q_wr      = (state_reg == S_OUT) && (qn_reg != 2'd2);

    // round up: add (a - r) when the remainder is non-zero
    assign pw_sum = {1'b0, dw_reg} + ((rw_reg == '0) ? '0 :
                    (PITCH_BITS+1)'({1'b0, align_w} - {1'b0, rw_reg[ALIGN_BITS-1:0]}));
    assign ph_sum = {1'b0, cmd_reg.plane_height} + ((rh_reg == '0) ? '0 :
                    HAL_BITS'({1'b0, align_h} - {1'b0, rh_reg[ALIGN_BITS-1:0]}));
    assign size_sat = (prod_reg > PROD_BITS'(SIZE_MAX)) ? SIZE_MAX : prod_reg[SIZE_BITS-1:0];

    always_comb
    begin
        q_in              = '0;
        q_in.err          = cmd_reg.err;
        q_in.last         = cmd_reg.last;
        if (!cmd_reg.err)
        begin
            q_in.plane_index  = cmd_reg.plane_index;
            q_in.plane_width  = cmd_reg.plane_width;
            q_in.plane_height = cmd_reg.plane_height;
            q_in.bpp          = cmd_reg.bpp;
            q_in.count        = cmd_reg.count;
            q_in.pitch        = pitch_reg;
            q_in.plane_size   = size_sat;
            q_in.plane_offset = (offs_reg > ACC_BITS'(OFFS_MAX)) ? OFFS_MAX
                                                                 : offs_reg[OFFS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            offs_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                        state_reg <= cmd.err ? S_OUT : S_DIV;
                    step_reg <= '0;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15)
                        state_reg <= S_RND;
                end
                S_RND: state_reg <= S_MUL;
                S_MUL: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (q_wr)
                    begin
                        state_reg <= S_IDLE;
                        if (cmd_reg.last)
                            offs_reg <= '0;
                        else
                            offs_reg <= offs_reg + ACC_BITS'(size_sat);
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg  <= cmd;
                dw_reg   <= PITCH_BITS'(cmd.plane_width) * PITCH_BITS'(cmd.bpp);
                shw_reg  <= PITCH_BITS'(cmd.plane_width) * PITCH_BITS'(cmd.bpp);
                shh_reg  <= PITCH_BITS'(cmd.plane_height);
                rw_reg   <= '0;
                rh_reg   <= '0;
                prod_reg <= '0;
                pitch_reg <= '0;
            end
            S_DIV:
            begin
                rw_reg  <= rem_step(rw_reg, shw_reg[PITCH_BITS-1], align_w);
                rh_reg  <= rem_step(rh_reg, shh_reg[PITCH_BITS-1], align_h);
                shw_reg <= shw_reg << 1;
                shh_reg <= shh_reg << 1;
            end
            S_RND:
            begin
                pitch_reg <= pw_sum[PITCH_BITS] ? PITCH_MAX : pw_sum[PITCH_BITS-1:0];
                hal_reg   <= ph_sum;
            end
            S_MUL: prod_reg <= pitch_reg * hal_reg;
            default: ;
        endcase
    end

    // result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg <= 1'b0;
            qr_reg <= 1'b0;
            qn_reg <= '0;
        end
        else
        begin
            if (q_wr)
                qw_reg <= ~qw_reg;
            if (res_pop && res_valid)
                qr_reg <= ~qr_reg;
            qn_reg <= qn_reg + {1'b0, q_wr} - {1'b0, res_pop && res_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
            q_reg[qw_reg] <= q_in;
    end

endmodule

@@ sv/image_plane_layout_calc.sv @@
// Top level of the image plane layout calculator.
// Depends on iplc_pkg, iplc_front, iplc_cmd_fifo and iplc_back.
//
// Usage:
//   Input queue: drive format, image_width and image_height with push high;
//   the item is taken at a rising edge where full is low.
//   Result queue: while empty is low the oldest result (one per plane, the
//   final one flagged by last) sits on the result ports; pop takes it.
//   An unsupported format yields one result with error and last set.
//   Configuration: cfg_we with cfg_index 0 writes align_width, index 1
//   align_height; a zero alignment acts as one. Write only while idle.
// Flow:
//   Each plane goes through the back end in turn: the bit-serial remainder
//   unit (one bit per cycle, pitch and height in parallel), then round,
//   multiply and write-out; an unsupported format goes straight to
//   write-out. The back end works on one plane at a time.
//   The front end splits items into a four-deep plane queue, so a new item
//   is taken while earlier planes are still being worked on.
// Reset: both queues empty, alignments return to 1.
// Stall: when pop is held low the two-entry result queue fills, the back
//   end holds its finished plane and the plane queue then backs up to full.
module image_plane_layout_calc
    import iplc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            format,
    input  logic [DIM_BITS-1:0]   image_width,
    input  logic [DIM_BITS-1:0]   image_height,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            plane_index,
    output logic [DIM_BITS-1:0]   plane_width,
    output logic [DIM_BITS-1:0]   plane_height,
    output logic [1:0]            bytes_per_pixel,
    output logic [PITCH_BITS-1:0] pitch,
    output logic [SIZE_BITS-1:0]  plane_size,
    output logic [OFFS_BITS-1:0]  plane_offset,
    output logic [1:0]            plane_count,
    output logic                  error,
    output logic                  last,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [ALIGN_BITS-1:0] cfg_wdata
);

    logic [ALIGN_BITS-1:0] align_w_reg, align_h_reg;
    logic [ALIGN_BITS-1:0] align_w_eff, align_h_eff;
    logic                  cmd_push, cmd_full, cmd_pop, cmd_valid;
    cmd_t                  cmd_in, cmd_out;
    logic                  res_valid;
    res_t                  res;

    // hold alignment registers; zero behaves as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_w_reg <= ALIGN_BITS'(1);
            align_h_reg <= ALIGN_BITS'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ALIGN_W)
                align_w_reg <= cfg_wdata;
            else
                align_h_reg <= cfg_wdata;
        end
    end

    assign align_w_eff = (align_w_reg == '0) ? ALIGN_BITS'(1) : align_w_reg;
    assign align_h_eff = (align_h_reg == '0) ? ALIGN_BITS'(1) : align_h_reg;

    iplc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .format       (format),
        .image_width  (image_width),
        .image_height (image_height),
        .cmd_push     (cmd_push),
        .cmd_full     (cmd_full),
        .cmd          (cmd_in)
    );

    iplc_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd      (cmd_pop),
        .rd_data (cmd_out),
        .valid   (cmd_valid)
    );

    iplc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .align_w   (align_w_eff),
        .align_h   (align_h_eff),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty           = !res_valid;
    assign plane_index     = res.plane_index;
    assign plane_width     = res.plane_width;
    assign plane_height    = res.plane_height;
    assign bytes_per_pixel = res.bpp;
    assign pitch           = res.pitch;
    assign plane_size      = res.plane_size;
    assign plane_offset    = res.plane_offset;
    assign plane_count     = res.count;
    assign error           = res.err;
    assign last            = res.last;

    // an error result always closes its item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error) |-> last)
        else $error("error result without last");

    // plane index stays below the plane count
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !error) |-> (plane_index < plane_count))
        else $error("plane index out of range");

    // last marks the final plane
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !error && last) |-> (plane_index + 2'd1 == plane_count))
        else $error("last on wrong plane");

    // first plane of an item starts at offset zero
    a_first_offs: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && plane_index == 2'd0) |-> (plane_offset == '0))
        else $error("first plane offset non-zero");

endmodule

@@ test/tb.sv @@
// Self-checking bench for image_plane_layout_calc: predicts each plane layout
// from format, width, height and the alignment registers. Depends on iplc_pkg.
module tb;
    import iplc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Format code the package leaves unnamed
    localparam logic [2:0] FMT_INVALID = 3'd7;
    localparam int         LAT_CYCLES  = 100;
    localparam int         WDOG_LIMIT  = 20000;

    typedef struct packed {
        logic [2:0]          fmt;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } frame_t;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [2:0]            format;
    logic [DIM_BITS-1:0]   image_width;
    logic [DIM_BITS-1:0]   image_height;
    logic                  empty;
    logic                  pop;
    logic [1:0]            plane_index;
    logic [DIM_BITS-1:0]   plane_width;
    logic [DIM_BITS-1:0]   plane_height;
    logic [1:0]            bytes_per_pixel;
    logic [PITCH_BITS-1:0] pitch;
    logic [SIZE_BITS-1:0]  plane_size;
    logic [OFFS_BITS-1:0]  plane_offset;
    logic [1:0]            plane_count;
    logic                  error;
    logic                  last;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [ALIGN_BITS-1:0] cfg_wdata;

    image_plane_layout_calc dut (.*);

    frame_t pending_frames[$];
    res_t   expected_planes[$];
    logic [ALIGN_BITS-1:0] row_align;
    logic [ALIGN_BITS-1:0] height_align;
    int  mismatches;
    int  idle_cycles;
    int  send_gap;
    int  pop_gap;
    bit  stimulus_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Short gaps mostly, an occasional long one; none at all in quiet spells
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint round_to(input longint v, input logic [ALIGN_BITS-1:0] a);
        longint d;
        d = (a == 0) ? 1 : longint'(a);
        return (v + d - 1) / d * d;
    endfunction

    // Work out every plane of one frame and queue the expected results
    function automatic void predict_layout(input frame_t f);
        res_t   r;
        int     n;
        longint pw;
        longint ph;
        longint bpp;
        longint p;
        longint sz;
        longint offs;
        case (f.fmt)
            FMT_YUV420, FMT_RGBP, FMT_BGRP: n = 3;
            FMT_NV12, FMT_NV21:             n = 2;
            FMT_RGB, FMT_BGR:               n = 1;
            default:                        n = 0;
        endcase
        if (n == 0)
        begin
            r = '0;
            r.err = 1'b1;
            r.last = 1'b1;
            expected_planes.push_back(r);
            return;
        end
        offs = 0;
        for (int i = 0; i < n; i++)
        begin
            pw = longint'(f.w);
            ph = longint'(f.h);
            bpp = 1;
            if (f.fmt == FMT_YUV420 && i != 0)
            begin
                pw = longint'(f.w >> 1);
                ph = longint'(f.h >> 1);
            end
            else if ((f.fmt == FMT_NV12 || f.fmt == FMT_NV21) && i != 0)
                ph = longint'(f.h >> 1);
            else if (f.fmt == FMT_RGB || f.fmt == FMT_BGR)
                bpp = 3;
            p = round_to(pw * bpp, row_align);
            if (p > 65535)
                p = 65535;
            sz = p * round_to(ph, height_align);
            if (sz > 64'd1073741823)
                sz = 64'd1073741823;
            r.plane_index = 2'(i);
            r.plane_width = DIM_BITS'(pw);
            r.plane_height = DIM_BITS'(ph);
            r.bpp = 2'(bpp);
            r.pitch = PITCH_BITS'(p);
            r.plane_size = SIZE_BITS'(sz);
            r.plane_offset = (offs > 64'd2147483647) ? OFFS_MAX : OFFS_BITS'(offs);
            r.count = 2'(n);
            r.err = 1'b0;
            r.last = (i == n - 1);
            expected_planes.push_back(r);
            offs += sz;
        end
    endfunction

    // Driver: present the head of the pending queue, advance on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_layout(pending_frames.pop_front());
                send_gap <= pick_gap($urandom_range(0, 3) == 0);
            end
            if ((push && !full) || !push)
            begin
                if (send_gap == 0 && pending_frames.size() != 0)
                begin
                    push <= 1'b1;
                    {format, image_width, image_height} <= pending_frames[0];
                end
                else
                begin
                    push <= 1'b0;
                    if (send_gap > 0 && !(push && !full))
                        send_gap <= send_gap - 1;
                end
            end
        end
    end

    // Monitor: pop at random, check each plane against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got = '{plane_index, plane_width, plane_height, bytes_per_pixel, pitch,
                        plane_size, plane_offset, plane_count, error, last};
                if (expected_planes.size() == 0)
                begin
                    $display("%0t: unexpected plane, actual %p", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = expected_planes.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: plane mismatch, expected %p actual %p",
                                 $time, want, got);
                        mismatches++;
                    end
                end
                pop_gap <= pick_gap($urandom_range(0, 3) == 0);
            end
            else if (pop_gap > 0)
                pop_gap <= pop_gap - 1;
            pop <= (pop_gap <= 1) && !(pop && !empty && pop_gap != 0);
            // Watchdog: count cycles where neither side moves an item
            if ((push && !full) || (pop && !empty) || stimulus_done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WDOG_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    function automatic frame_t random_frame();
        frame_t f;
        int sel;
        f.fmt = 3'($urandom_range(0, 7));
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            f.w = DIM_BITS'($urandom_range(0, 700));
            f.h = DIM_BITS'($urandom_range(0, 500));
        end
        else
        begin
            f.w = DIM_BITS'($urandom);
            f.h = DIM_BITS'($urandom);
        end
        return f;
    endfunction

    task automatic write_reg(input logic idx, input logic [ALIGN_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ALIGN_W)
            row_align = val;
        else
            height_align = val;
    endtask

    // Hold until every queued frame has come back, then let the back end drain
    task automatic drain();
        while (pending_frames.size() != 0 || push || expected_planes.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        static logic [ALIGN_BITS-1:0] aw[6] =
            '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd64, 13'd3};
        static logic [ALIGN_BITS-1:0] ah[6] =
            '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd2, 13'd7};
        mismatches = 0;
        stimulus_done = 1'b0;
        row_align = 13'd1;
        height_align = 13'd1;
        cfg_we = 1'b0;
        cfg_index = REG_ALIGN_W;
        cfg_wdata = '0;
        push = 1'b0;
        pop = 1'b0;
        format = FMT_YUV420;
        image_width = '0;
        image_height = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every format at the extremes, odd sizes, the invalid code
        for (int fm = 0; fm < 8; fm++)
        begin
            pending_frames.push_back('{fm[2:0], 14'd0, 14'd0});
            pending_frames.push_back('{fm[2:0], 14'h3FFF, 14'h3FFF});
        end
        pending_frames.push_back('{FMT_YUV420, 14'd7, 14'd5});
        pending_frames.push_back('{FMT_NV21, 14'd1, 14'd1});
        pending_frames.push_back('{FMT_RGB, 14'h1555, 14'd3});
        pending_frames.push_back('{FMT_INVALID, 14'h2AAA, 14'h1555});
        drain();

        // Random phases across alignment settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_ALIGN_W, aw[ph]);
            write_reg(REG_ALIGN_H, ah[ph]);
            for (int k = 0; k < 80; k++)
                pending_frames.push_back(random_frame());
            drain();
        end
        stimulus_done = 1'b1;

        if (mismatches == 0 && expected_planes.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

@@ files.f @@
sv/iplc_pkg.sv
sv/iplc_front.sv
sv/iplc_cmd_fifo.sv
sv/iplc_back.sv
sv/image_plane_layout_calc.sv
test/tb.sv
